// ===== rtl/core/yaw_torque_split_core_macros.svh =====
// ---------------------------------------------------------------------------
// Yaw torque split assertion macros
// Shared concurrent assertion forms for the yaw torque split checker.
// ---------------------------------------------------------------------------
`ifndef YAW_TORQUE_SPLIT_CORE_MACROS_SVH
`define YAW_TORQUE_SPLIT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define YTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define YTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/yts_pkg.sv =====
// ---------------------------------------------------------------------------
// Yaw torque split package
// Widths, register map constants and item types of the yaw torque split core.
// ---------------------------------------------------------------------------
package yts_pkg;

    localparam int FW         = 32;
    localparam int YW         = 48;
    localparam int HW         = 16;
    localparam int DW         = ((FW + 2 > YW) ? FW + 2 : YW) + 2;
    localparam int BPS        = 4;
    localparam int DIV_STAGES = YW / BPS;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int RIDX_W     = PADDR_W - 2;

    localparam logic [RIDX_W-1:0] REG_TRK_HALF = '0;
    localparam logic [HW-1:0]     TRK_HALF_RST = HW'(1);

    typedef struct packed {
        logic [FW-1:0]        force_dmd;
        logic signed [YW-1:0] yaw_tgt;
        logic [FW-1:0]        cap_left;
        logic [FW-1:0]        cap_right;
    } t_yts_in;

    typedef struct packed {
        logic                 feasible;
        logic [FW-1:0]        rear_left_force;
        logic [FW-1:0]        rear_right_force;
        logic [FW-1:0]        admitted_force;
        logic [FW-1:0]        holdback_force;
        logic signed [YW-1:0] achieved_yaw;
    } t_yts_out;

    typedef struct packed {
        logic [FW-1:0]        total;
        logic signed [YW-1:0] yaw;
        logic [FW-1:0]        lcap;
        logic [FW-1:0]        rcap;
    } t_yts_side;

endpackage

// ===== rtl/core/yts_apb.sv =====
// ---------------------------------------------------------------------------
// Yaw torque split register port
// APB-style slave holding the half track register.
// ---------------------------------------------------------------------------
module yts_apb
    import yts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [HW-1:0]      o_trk_half
);

    logic [HW-1:0]     r_trk_half;
    logic [RIDX_W-1:0] reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_TRK_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk_half <= TRK_HALF_RST;
        end else if (wr_en) begin
            r_trk_half <= pwdata[HW-1:0];
        end
    end

    assign prdata     = (reg_idx == REG_TRK_HALF) ? PDATA_W'(r_trk_half) : '0;
    assign pready     = 1'b1;
    assign o_trk_half = r_trk_half;

endmodule

// ===== rtl/core/yts_div.sv =====
// ---------------------------------------------------------------------------
// Yaw torque split divider
// Pipelined restoring division of the yaw moment magnitude by the half track.
// ---------------------------------------------------------------------------
module yts_div
    import yts_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_yts_in         i_data,
    input  logic [HW-1:0]   i_trk_half,
    output logic            o_valid,
    output logic [YW-1:0]   o_quot,
    output logic            o_rem_nz,
    output t_yts_side       o_side
);

    typedef struct packed {
        logic [HW-1:0] rem;
        logic [YW-1:0] quo;
    } t_div_st;

    function automatic t_div_st div_iter(input t_div_st cur, input logic [HW-1:0] ht);
        t_div_st     st;
        logic [HW:0] trial;
        st = cur;
        for (int b = 0; b < BPS; b++) begin
            trial  = {st.rem, st.quo[YW-1]};
            st.quo = {st.quo[YW-2:0], 1'b0};
            if (trial >= {1'b0, ht}) begin
                trial     = trial - {1'b0, ht};
                st.quo[0] = 1'b1;
            end
            st.rem = trial[HW-1:0];
        end
        return st;
    endfunction

    logic [DIV_STAGES:0] r_vld;
    t_div_st             r_st   [DIV_STAGES+1];
    t_yts_side           r_side [DIV_STAGES+1];
    t_div_st             n_st0;
    t_yts_side           n_side0;

    always_comb begin
        n_st0.rem     = '0;
        n_st0.quo     = i_data.yaw_tgt[YW-1] ? (~i_data.yaw_tgt + YW'(1))
                                             : i_data.yaw_tgt;
        n_side0.total = i_data.force_dmd;
        n_side0.yaw   = i_data.yaw_tgt;
        n_side0.lcap  = i_data.cap_left;
        n_side0.rcap  = i_data.cap_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0]   <= n_st0;
            r_side[0] <= n_side0;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_st[s+1]   <= div_iter(r_st[s], i_trk_half);
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid  = r_vld[DIV_STAGES];
    assign o_quot   = r_st[DIV_STAGES].quo;
    assign o_rem_nz = (r_st[DIV_STAGES].rem != '0);
    assign o_side   = r_side[DIV_STAGES];

endmodule

// ===== rtl/core/yts_alloc.sv =====
// ---------------------------------------------------------------------------
// Yaw torque split allocator
// Bounds the admitted force, applies the parity step and forms the result.
// ---------------------------------------------------------------------------
module yts_alloc
    import yts_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [YW-1:0] i_quot,
    input  logic          i_rem_nz,
    input  t_yts_side     i_side,
    input  logic [HW-1:0] i_trk_half,
    output logic          o_valid,
    output t_yts_out      o_data
);

    logic [4:0]           r_vld;
    t_yts_side            r_side [4];
    logic                 r_fail [4];
    logic signed [DW-1:0] r_diff [4];
    logic signed [DW-1:0] r_adiff [4];
    logic signed [DW-1:0] r_lb;
    logic signed [DW-1:0] r_rb [2];
    logic signed [DW-1:0] r_m1;
    logic signed [DW-1:0] r_adm;
    t_yts_out             r_out;

    logic signed [DW-1:0] n_qext;
    logic signed [DW-1:0] n_diff;
    logic signed [DW-1:0] n_lcap2;
    logic signed [DW-1:0] n_rcap2;
    logic signed [DW-1:0] n_total;
    logic signed [DW-1:0] n_adm0;
    logic signed [DW-1:0] n_adm;
    logic signed [DW-1:0] n_rl;
    logic signed [DW-1:0] n_rr;
    logic                 n_fail;
    t_yts_out             n_out;

    always_comb begin
        n_qext  = $signed({{(DW-YW){1'b0}}, i_quot});
        n_diff  = i_side.yaw[YW-1] ? -n_qext : n_qext;
        n_lcap2 = $signed({{(DW-FW-1){1'b0}}, r_side[0].lcap, 1'b0});
        n_rcap2 = $signed({{(DW-FW-1){1'b0}}, r_side[0].rcap, 1'b0});
        n_total = $signed({{(DW-FW){1'b0}}, r_side[1].total});
        n_adm0  = (r_m1 < r_rb[1]) ? r_m1 : r_rb[1];
        n_adm   = n_adm0 - $signed(DW'(n_adm0[0] ^ r_diff[2][0]));
        n_rl    = (r_adm - r_diff[3]) >>> 1;
        n_rr    = (r_adm + r_diff[3]) >>> 1;
        n_fail  = r_fail[3] || (r_adm < r_adiff[3]);

        n_out = '0;
        if (!n_fail) begin
            n_out.feasible         = 1'b1;
            n_out.rear_left_force  = n_rl[FW-1:0];
            n_out.rear_right_force = n_rr[FW-1:0];
            n_out.admitted_force   = r_adm[FW-1:0];
            n_out.holdback_force   = r_side[3].total - r_adm[FW-1:0];
            n_out.achieved_yaw     = r_side[3].yaw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0]  <= i_side;
            r_fail[0]  <= i_rem_nz || (i_trk_half == '0);
            r_diff[0]  <= n_diff;
            r_adiff[0] <= n_qext;

            r_side[1]  <= r_side[0];
            r_fail[1]  <= r_fail[0];
            r_diff[1]  <= r_diff[0];
            r_adiff[1] <= r_adiff[0];
            r_lb       <= n_lcap2 + r_diff[0];
            r_rb[0]    <= n_rcap2 - r_diff[0];

            r_side[2]  <= r_side[1];
            r_fail[2]  <= r_fail[1] || (r_lb < r_adiff[1]) || (r_rb[0] < r_adiff[1]);
            r_diff[2]  <= r_diff[1];
            r_adiff[2] <= r_adiff[1];
            r_m1       <= (n_total < r_lb) ? n_total : r_lb;
            r_rb[1]    <= r_rb[0];

            r_side[3]  <= r_side[2];
            r_fail[3]  <= r_fail[2];
            r_diff[3]  <= r_diff[2];
            r_adiff[3] <= r_adiff[2];
            r_adm      <= n_adm;

            r_out      <= n_out;
        end
    end

    assign o_valid = r_vld[4];
    assign o_data  = r_out;

endmodule

// ===== rtl/core/yaw_torque_split_core.sv =====
// ---------------------------------------------------------------------------
// Yaw torque split core
// Splits a rear axle force demand between the rear wheels for an exact yaw.
// ---------------------------------------------------------------------------
// The core takes one item per clock cycle while its output is not stalled:
// an input register holds the yaw magnitude, twelve divider stages retire four
// quotient bits each of the division by the half track, and five allocation
// stages bound, round and split the admitted force. When the output item is
// not taken, the whole pipeline holds and input ready drops. The half track
// register sits at byte address 0 of the register port.
module yaw_torque_split_core
    import yts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_yts_in            i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_yts_out           o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [HW-1:0] trk_half;
    logic          pipe_en;
    logic          div_valid;
    logic [YW-1:0] div_quot;
    logic          div_rem_nz;
    t_yts_side     div_side;

    assign pipe_en    = !o_out_valid || i_out_ready;
    assign o_in_ready = pipe_en;

    yts_apb u_apb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_trk_half (trk_half)
    );

    yts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_valid    (i_in_valid),
        .i_data     (i_in_data),
        .i_trk_half (trk_half),
        .o_valid    (div_valid),
        .o_quot     (div_quot),
        .o_rem_nz   (div_rem_nz),
        .o_side     (div_side)
    );

    yts_alloc u_alloc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_valid    (div_valid),
        .i_quot     (div_quot),
        .i_rem_nz   (div_rem_nz),
        .i_side     (div_side),
        .i_trk_half (trk_half),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data)
    );

endmodule

// ===== rtl/core/yts_checker.sv =====
// ---------------------------------------------------------------------------
// Yaw torque split checker
// Port-level assertions on the yaw torque split core, attached by bind.
// ---------------------------------------------------------------------------
`include "yaw_torque_split_core_macros.svh"

module yts_checker
    import yts_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input t_yts_in            i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input t_yts_out           o_out_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready
);

    `YTS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "output item dropped before it was taken")
    `YTS_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready, "input accepted while output is stalled")
    `YTS_ASSERT_IMP(a_infeasible_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.feasible, (o_out_data.rear_left_force == '0) && (o_out_data.rear_right_force == '0) && (o_out_data.admitted_force == '0) && (o_out_data.holdback_force == '0) && (o_out_data.achieved_yaw == '0), "infeasible item carries nonzero fields")
    `YTS_ASSERT_IMP(a_split_sum, i_clk, i_rst_n, o_out_valid && o_out_data.feasible, ((FW+1)'(o_out_data.rear_left_force) + (FW+1)'(o_out_data.rear_right_force)) == (FW+1)'(o_out_data.admitted_force), "wheel forces do not add up to the admitted force")

endmodule

bind yaw_torque_split_core yts_checker u_yts_checker (.*);
